// ----- rtl/fcte_pkg.sv -----
// Shared types, codes and entry helpers for the cluster table engine.
`timescale 1ns / 1ps
`default_nettype none
package fcte_pkg;

  localparam int unsigned EntryW  = 28;
  localparam int unsigned ClusterW = 16;
  localparam int unsigned CountW  = 17;

  localparam logic [2:0] MODE_READ  = 3'd0;
  localparam logic [2:0] MODE_WRITE = 3'd1;
  localparam logic [2:0] MODE_FIND  = 3'd2;
  localparam logic [2:0] MODE_TRAV  = 3'd3;
  localparam logic [2:0] MODE_CHAIN = 3'd4;

  localparam logic [1:0] FAT12 = 2'd0;
  localparam logic [1:0] FAT16 = 2'd1;
  localparam logic [1:0] FAT32 = 2'd2;

  localparam logic [1:0] CFG_FAT_TYPE      = 2'd0;
  localparam logic [1:0] CFG_CLUSTER_COUNT = 2'd1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [1:0] STATUS_LIMIT   = 2'd2;

  localparam logic [EntryW-1:0] Mask32 = 28'hfffffff;
  localparam logic [EntryW-1:0] Mask16 = 28'h000ffff;
  localparam logic [EntryW-1:0] Mask12 = 28'h0000fff;
  localparam logic [EntryW-1:0] Eoc32  = 28'hffffff8;
  localparam logic [EntryW-1:0] Eoc16  = 28'h000fff8;
  localparam logic [EntryW-1:0] Eoc12  = 28'h0000ff8;

  typedef struct packed {
    logic [1:0]        fat_type;
    logic [CountW-1:0] cluster_count;
  } cfg_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic [ClusterW-1:0] cluster;
    logic [EntryW-1:0]   value;
    logic [15:0]         count;
  } req_t;

  typedef struct packed {
    logic [CountW-1:0] chain_length;
    logic              end_of_chain;
    logic [EntryW-1:0] result_cluster;
    logic [1:0]        status;
  } rsp_t;

  function automatic logic [EntryW-1:0] type_mask(input logic [1:0] ft);
    logic [EntryW-1:0] m;
    case (ft)
      FAT32:   m = Mask32;
      FAT16:   m = Mask16;
      default: m = Mask12;
    endcase
    return m;
  endfunction

  function automatic logic is_eoc(input logic [EntryW-1:0] e, input logic [1:0] ft);
    logic r;
    case (ft)
      FAT32:   r = (e >= Eoc32);
      FAT16:   r = (e >= Eoc16);
      default: r = (e >= Eoc12);
    endcase
    return r | (e == '0);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fat_cluster_table_engine_unit.sv -----
// Top level of the cluster table engine: ports, configuration registers, memory.
//
// channel     direction  handshake                  payload
// s_axis      in         s_axis_tvalid/tready       tuser mode, tdata cluster/value/count
// m_axis      out        m_axis_tvalid/tready       tdata status/result/eoc/length
// cfg         in         cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// After reset a clearing pass writes zero to all MAX_CLUSTERS entries, one per
// cycle; s_axis_tready stays low meanwhile, configuration writes are taken.
// A write goes from acceptance straight to the output state; a read first passes
// through the issue state (memory read) and the evaluate state; find-free, traverse
// and chain length repeat both per entry visited. A result waits in the output
// register while m_axis_tready is low; one more item is held at its finish.
`timescale 1ns / 1ps
`default_nettype none
module fat_cluster_table_engine_unit #(
  parameter int unsigned MAX_CLUSTERS = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // cluster[15:0], value[43:16], count[59:44]
  input  wire logic [2:0]  s_axis_tuser,   // mode[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // status[1:0], result_cluster[29:2],
                                           // end_of_chain[30], chain_length[47:31]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);
  import fcte_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_CLUSTERS);

  cfg_t cfg_q;
  req_t req;
  rsp_t rsp;

  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fat_type <= FAT32;
      cfg_q.cluster_count <= 17'h10000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FAT_TYPE:      cfg_q.fat_type <= cfg_data_i[1:0];
        CFG_CLUSTER_COUNT: cfg_q.cluster_count <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign req.mode    = s_axis_tuser;
  assign req.cluster = s_axis_tdata[15:0];
  assign req.value   = s_axis_tdata[43:16];
  assign req.count   = s_axis_tdata[59:44];

  assign m_axis_tdata = {rsp.chain_length, rsp.end_of_chain, rsp.result_cluster, rsp.status};

  fcte_engine #(
    .MAX_CLUSTERS(MAX_CLUSTERS),
    .ADDR_W(AddrW)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .cfg_i(cfg_q),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .req_i(req),
    .rsp_valid_o(m_axis_tvalid),
    .rsp_ready_i(m_axis_tready),
    .rsp_o(rsp),
    .mem_we_o(we),
    .mem_waddr_o(waddr),
    .mem_wdata_o(wdata),
    .mem_re_o(re),
    .mem_raddr_o(raddr),
    .mem_rdata_i(rdata)
  );

  fcte_link_ram #(
    .DEPTH(MAX_CLUSTERS),
    .DATA_W(EntryW),
    .ADDR_W(AddrW)
  ) u_ram (
    .clk_i,
    .we_i(we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i(re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule
`default_nettype wire

// ----- rtl/fcte_link_ram.sv -----
// Link table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module fcte_link_ram #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned DATA_W = 28,
  parameter int unsigned ADDR_W = 16
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/fcte_engine.sv -----
// Operation sequencer: clearing pass, single writes, read-only walks, result register.
`timescale 1ns / 1ps
`default_nettype none
module fcte_engine #(
  parameter int unsigned MAX_CLUSTERS = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fcte_pkg::cfg_t       cfg_i,
  input  wire logic                 req_valid_i,
  output logic                      req_ready_o,
  input  wire fcte_pkg::req_t       req_i,
  output logic                      rsp_valid_o,
  input  wire logic                 rsp_ready_i,
  output fcte_pkg::rsp_t            rsp_o,
  output logic                      mem_we_o,
  output logic [ADDR_W-1:0]         mem_waddr_o,
  output logic [fcte_pkg::EntryW-1:0] mem_wdata_o,
  output logic                      mem_re_o,
  output logic [ADDR_W-1:0]         mem_raddr_o,
  input  wire logic [fcte_pkg::EntryW-1:0] mem_rdata_i
);
  import fcte_pkg::*;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_ISSUE, ST_EVAL, ST_OUT} state_e;

  localparam logic [28:0] MaxC = 29'(MAX_CLUSTERS);
  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(MAX_CLUSTERS - 1);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [2:0]        op_q, op_d;
  logic [15:0]       cnt_q, cnt_d;
  logic [EntryW-1:0] cur_q, cur_d;
  logic [CountW-1:0] ctr_q, ctr_d;
  logic [15:0]       hint_q, hint_d;
  logic [1:0]        status_q, status_d;
  logic [EntryW-1:0] res_q, res_d;
  logic              valid_q, valid_d;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic [EntryW-1:0] mask, entry, scan_addr;
  logic [28:0]       lim;
  logic              cur_in_rng, accept;

  assign mask       = type_mask(cfg_i.fat_type);
  assign entry      = mem_rdata_i & mask;
  assign cur_in_rng = ({1'b0, cur_q} < MaxC);
  assign lim        = ({12'b0, cfg_i.cluster_count} < MaxC) ? {12'b0, cfg_i.cluster_count} : MaxC;
  assign scan_addr  = {11'b0, ctr_q};
  assign req_ready_o = (state_q == ST_IDLE);
  assign accept     = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o      = rsp_q;

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    op_d = op_q;
    cnt_d = cnt_q;
    cur_d = cur_q;
    ctr_d = ctr_q;
    hint_d = hint_q;
    status_d = status_q;
    res_d = res_q;
    valid_d = valid_q;
    rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q & ~rsp_ready_i;
    mem_we_o = 1'b0;
    mem_waddr_o = cur_q[ADDR_W-1:0];
    mem_wdata_o = '0;
    mem_re_o = 1'b0;
    mem_raddr_o = (op_q == MODE_FIND) ? scan_addr[ADDR_W-1:0] : cur_q[ADDR_W-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o = 1'b1;
        mem_waddr_o = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_d = req_i.mode;
          cnt_d = req_i.count;
          cur_d = {12'b0, req_i.cluster};
          ctr_d = '0;
          status_d = STATUS_OK;
          res_d = '0;
          valid_d = 1'b1;
          state_d = ST_ISSUE;
          case (req_i.mode) inside
            MODE_WRITE: begin
              state_d = ST_OUT;
              if ({13'b0, req_i.cluster} < MaxC) begin
                mem_we_o = 1'b1;
                mem_waddr_o = req_i.cluster[ADDR_W-1:0];
                mem_wdata_o = req_i.value & mask;
                res_d = req_i.value & mask;
              end
            end
            MODE_FIND: ctr_d = {1'b0, hint_q};
            MODE_READ, MODE_TRAV, MODE_CHAIN: ;
            default: begin
              valid_d = 1'b0;
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_ISSUE: begin
        state_d = ST_OUT;
        case (op_q)
          MODE_READ: begin
            if (cur_in_rng) begin
              mem_re_o = 1'b1;
              state_d = ST_EVAL;
            end
          end
          MODE_FIND: begin
            if ({12'b0, ctr_q} >= lim) begin
              status_d = STATUS_NO_FREE;
            end else begin
              mem_re_o = 1'b1;
              state_d = ST_EVAL;
            end
          end
          MODE_TRAV: begin
            res_d = cur_q;
            if ({1'b0, cnt_q} <= ctr_q) begin
              state_d = ST_OUT;
            end else if (ctr_q >= cfg_i.cluster_count) begin
              status_d = STATUS_LIMIT;
            end else if (cur_in_rng) begin
              mem_re_o = 1'b1;
              state_d = ST_EVAL;
            end
          end
          default: begin
            res_d = cur_q;
            if (is_eoc(cur_q, cfg_i.fat_type)) begin
              state_d = ST_OUT;
            end else if (ctr_q >= cfg_i.cluster_count) begin
              status_d = STATUS_LIMIT;
            end else if (cur_in_rng) begin
              mem_re_o = 1'b1;
              state_d = ST_EVAL;
            end else begin
              cur_d = '0;
              ctr_d = ctr_q + 1'b1;
              state_d = ST_ISSUE;
            end
          end
        endcase
      end
      ST_EVAL: begin
        state_d = ST_ISSUE;
        case (op_q)
          MODE_READ: begin
            res_d = entry;
            state_d = ST_OUT;
          end
          MODE_FIND: begin
            if (entry == '0) begin
              hint_d = ctr_q[15:0];
              res_d = scan_addr;
              state_d = ST_OUT;
            end else begin
              ctr_d = ctr_q + 1'b1;
            end
          end
          MODE_TRAV: begin
            if (is_eoc(entry, cfg_i.fat_type)) begin
              res_d = cur_q;
              state_d = ST_OUT;
            end else begin
              cur_d = entry;
              ctr_d = ctr_q + 1'b1;
            end
          end
          default: begin
            cur_d = entry;
            ctr_d = ctr_q + 1'b1;
          end
        endcase
      end
      ST_OUT: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_valid_d = 1'b1;
          rsp_d.status = status_q;
          rsp_d.result_cluster = res_q;
          rsp_d.end_of_chain = valid_q && is_eoc(res_q, cfg_i.fat_type);
          rsp_d.chain_length = (op_q == MODE_CHAIN) ? ctr_q : '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      hint_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      hint_q <= hint_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    cnt_q <= cnt_d;
    cur_q <= cur_d;
    ctr_q <= ctr_d;
    status_q <= status_d;
    res_q <= res_d;
    valid_q <= valid_d;
    rsp_q <= rsp_d;
  end

endmodule
`default_nettype wire

// ----- bench/tb_fat_cluster_table_engine_unit.sv -----
// Self-checking testbench for the cluster table engine: directed table, random phases.
`timescale 1ns / 1ps
module tb_fat_cluster_table_engine_unit;
  import fcte_pkg::*;

  localparam int unsigned TableDepth = 65536;
  localparam int unsigned PhaseCnt = 10;
  localparam int unsigned PhaseItems = 125;
  localparam int unsigned QuietTail = 150;

  typedef struct {
    logic [2:0]  mode;
    logic [15:0] cluster;
    logic [27:0] value;
    logic [15:0] count;
    bit          typed;
    rsp_t        rsp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  logic [27:0]  link_mem [TableDepth];
  logic [15:0]  free_hint;
  logic [1:0]   cur_fat_type;
  logic [16:0]  cur_cluster_count;
  rsp_t         pending_rsp [$];
  int unsigned  mismatches = 0;
  int unsigned  items_sent = 0;
  int unsigned  rsp_seen = 0;
  int unsigned  limit_hits = 0;
  int unsigned  nofree_hits = 0;
  bit           quiet = 1'b0;
  row_t         directed [$];

  fat_cluster_table_engine_unit DUT (.*);

  always #6 clk_i = ~clk_i;

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [27:0] entry_mask(input logic [1:0] ft);
    if (ft == FAT32) return 28'hfffffff;
    if (ft == FAT16) return 28'h000ffff;
    return 28'h0000fff;
  endfunction

  function automatic bit chain_end(input logic [27:0] e, input logic [1:0] ft);
    logic [27:0] thr;
    thr = (ft == FAT32) ? 28'hffffff8 : (ft == FAT16) ? 28'h000fff8 : 28'h0000ff8;
    return (e == '0) || (e >= thr);
  endfunction

  function automatic logic [27:0] link_of(input logic [27:0] c);
    if (c >= TableDepth) return '0;
    return link_mem[c[15:0]] & entry_mask(cur_fat_type);
  endfunction

  task automatic predict_op(input logic [2:0] mode, input logic [15:0] cl,
                            input logic [27:0] val, input logic [15:0] cnt,
                            output rsp_t r);
    int unsigned lim;
    int unsigned c;
    int unsigned i;
    logic [27:0] cur;
    logic [27:0] e;
    bit found;
    r = '0;
    case (mode)
      MODE_READ: r.result_cluster = link_of({12'd0, cl});
      MODE_WRITE: begin
        r.result_cluster = val & entry_mask(cur_fat_type);
        link_mem[cl] = r.result_cluster;
      end
      MODE_FIND: begin
        lim = (cur_cluster_count > TableDepth) ? TableDepth : cur_cluster_count;
        found = 1'b0;
        for (c = free_hint; c < lim; c++) begin
          if (link_of(c[27:0]) == '0) begin
            found = 1'b1;
            break;
          end
        end
        if (found) begin
          free_hint = c[15:0];
          r.result_cluster = c[27:0];
        end else begin
          r.status = STATUS_NO_FREE;
        end
      end
      MODE_TRAV: begin
        cur = {12'd0, cl};
        for (i = 0; i < cnt; i++) begin
          if (i >= cur_cluster_count) begin
            r.status = STATUS_LIMIT;
            break;
          end
          e = link_of(cur);
          if (chain_end(e, cur_fat_type)) break;
          cur = e;
        end
        r.result_cluster = cur;
      end
      MODE_CHAIN: begin
        cur = {12'd0, cl};
        i = 0;
        while (!chain_end(cur, cur_fat_type)) begin
          if (i >= cur_cluster_count) begin
            r.status = STATUS_LIMIT;
            break;
          end
          cur = link_of(cur);
          i++;
        end
        r.result_cluster = cur;
        r.chain_length = i[16:0];
      end
      default: ;
    endcase
    if (mode <= MODE_CHAIN) r.end_of_chain = chain_end(r.result_cluster, cur_fat_type);
  endtask

  task automatic send_op(input logic [2:0] mode, input logic [15:0] cl,
                         input logic [27:0] val, input logic [15:0] cnt,
                         input bit typed, input rsp_t typed_rsp);
    rsp_t r;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = mode;
    s_axis_tdata = {4'd0, cnt, val, cl};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_op(mode, cl, val, cnt, r);
    if (r.status == STATUS_LIMIT) limit_hits++;
    if (r.status == STATUS_NO_FREE) nofree_hits++;
    pending_rsp.push_back(typed ? typed_rsp : r);
    items_sent++;
  endtask

  task automatic sender_gap();
    int unsigned n;
    if (quiet || $urandom_range(0, 4) != 0) return;
    n = $urandom_range(1, 12);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_FAT_TYPE) cur_fat_type = data[1:0];
    else cur_cluster_count = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic row_t mk(input logic [2:0] mode, input logic [15:0] cl,
                              input logic [27:0] val, input logic [15:0] cnt,
                              input bit typed = 1'b0, input logic [1:0] st = '0,
                              input logic [27:0] res = '0, input logic eoc = 1'b0);
    row_t t;
    t.mode = mode;
    t.cluster = cl;
    t.value = val;
    t.count = cnt;
    t.typed = typed;
    t.rsp = '0;
    t.rsp.status = st;
    t.rsp.result_cluster = res;
    t.rsp.end_of_chain = eoc;
    return t;
  endfunction

  task automatic random_op(input int unsigned region);
    logic [2:0]  mode;
    logic [15:0] cl;
    logic [27:0] val;
    logic [15:0] cnt;
    int unsigned pick;
    bit big;
    rsp_t none;
    none = '0;
    big = (cur_cluster_count > 256);
    pick = $urandom_range(0, 99);
    if (pick < 35) mode = MODE_WRITE;
    else if (pick < 50) mode = MODE_READ;
    else if (pick < 62) mode = MODE_FIND;
    else if (pick < 80) mode = MODE_TRAV;
    else if (pick < 95) mode = (big && $urandom_range(0, 40) != 0) ? MODE_TRAV : MODE_CHAIN;
    else mode = 3'($urandom_range(0, 7));
    cl = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, region + 2));
    pick = $urandom_range(0, 99);
    if (pick < 45) val = 28'($urandom_range(0, region + 2));
    else if (pick < 65) val = 28'hfffffff - 28'($urandom_range(0, 7)) & entry_mask(cur_fat_type)
                              | ($urandom_range(0, 1) ? 28'hffff000 : 28'h0);
    else if (pick < 78) val = '0;
    else val = 28'($urandom);
    if (!big && $urandom_range(0, 7) == 0) cnt = 16'($urandom);
    else cnt = 16'($urandom_range(0, 40));
    send_op(mode, cl, val, cnt, 1'b0, none);
  endtask

  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else if (!quiet && rst_ni && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        stall = $urandom_range(1, 12) - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = rsp_t'(m_axis_tdata);
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        $display("%t unexpected result %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status) begin
          $display("%t status exp %0d got %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.result_cluster !== want.result_cluster) begin
          $display("%t result_cluster exp %h got %h", $time, want.result_cluster,
                   got.result_cluster);
          mismatches++;
        end
        if (got.end_of_chain !== want.end_of_chain) begin
          $display("%t end_of_chain exp %b got %b", $time, want.end_of_chain,
                   got.end_of_chain);
          mismatches++;
        end
        if (got.chain_length !== want.chain_length) begin
          $display("%t chain_length exp %0d got %0d", $time, want.chain_length,
                   got.chain_length);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [1:0]  phase_ft [PhaseCnt] = '{FAT32, FAT12, FAT16, 2'd3, FAT32,
                                          FAT16, FAT12, FAT32, 2'd3, FAT16};
    logic [16:0] phase_cc [PhaseCnt] = '{17'd65536, 17'd2, 17'd2, 17'd16, 17'd128,
                                          17'd64, 17'd8, 17'd3, 17'd100, 17'd65536};
    int unsigned region;
    int unsigned total;
    foreach (link_mem[k]) link_mem[k] = '0;
    free_hint = '0;
    cur_fat_type = FAT32;
    cur_cluster_count = 17'd65536;

    directed.push_back(mk(MODE_READ, 16'd0, 28'd0, 16'd0, 1, STATUS_OK, 28'd0, 1'b1));
    directed.push_back(mk(MODE_FIND, 16'd0, 28'd0, 16'd0, 1, STATUS_OK, 28'd0, 1'b1));
    directed.push_back(mk(3'd5, 16'hffff, 28'hfffffff, 16'hffff, 1));
    directed.push_back(mk(3'd6, 16'd1, 28'd1, 16'd1, 1));
    directed.push_back(mk(3'd7, 16'd2, 28'd2, 16'd2, 1));
    directed.push_back(mk(MODE_WRITE, 16'hffff, 28'hfffffff, 16'd0, 1, STATUS_OK,
                          28'hfffffff, 1'b1));
    directed.push_back(mk(MODE_READ, 16'hffff, 28'h5a5a5a5, 16'hffff, 1, STATUS_OK,
                          28'hfffffff, 1'b1));
    directed.push_back(mk(MODE_WRITE, 16'd0, 28'd1, 16'd0, 1, STATUS_OK, 28'd1, 1'b0));
    directed.push_back(mk(MODE_WRITE, 16'd1, 28'd2, 16'd0));
    directed.push_back(mk(MODE_WRITE, 16'd2, 28'hffffff8, 16'd0, 1, STATUS_OK,
                          28'hffffff8, 1'b1));
    directed.push_back(mk(MODE_WRITE, 16'd3, 28'hffffff7, 16'd0));
    directed.push_back(mk(MODE_FIND, 16'd0, 28'd0, 16'd0));
    directed.push_back(mk(MODE_TRAV, 16'd0, 28'd0, 16'd0));
    directed.push_back(mk(MODE_TRAV, 16'd0, 28'd0, 16'd1));
    directed.push_back(mk(MODE_TRAV, 16'd0, 28'd0, 16'd5));
    directed.push_back(mk(MODE_TRAV, 16'd3, 28'd0, 16'hffff));
    directed.push_back(mk(MODE_CHAIN, 16'd0, 28'd0, 16'd0));
    directed.push_back(mk(MODE_CHAIN, 16'd1, 28'd0, 16'd0));
    directed.push_back(mk(MODE_CHAIN, 16'd4, 28'd0, 16'd0));
    directed.push_back(mk(MODE_WRITE, 16'd10, 28'd10, 16'd0));
    directed.push_back(mk(MODE_CHAIN, 16'd10, 28'd0, 16'd0));
    directed.push_back(mk(MODE_TRAV, 16'd10, 28'd0, 16'hffff));
    directed.push_back(mk(MODE_FIND, 16'd0, 28'd0, 16'd0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[k])
      send_op(directed[k].mode, directed[k].cluster, directed[k].value, directed[k].count,
              directed[k].typed, directed[k].rsp);

    total = 0;
    for (int p = 0; p < PhaseCnt; p++) begin
      drain();
      write_reg(CFG_FAT_TYPE, {15'd0, phase_ft[p]});
      write_reg(CFG_CLUSTER_COUNT, phase_cc[p]);
      region = (phase_cc[p] > 64) ? 64 : phase_cc[p];
      for (int k = 0; k < PhaseItems; k++) begin
        if (total + QuietTail >= PhaseCnt * PhaseItems) quiet = 1'b1;
        sender_gap();
        random_op(region);
        total++;
      end
    end
    drain();

    $display("Sent %0d operations over %0d table settings; %0d results checked,",
             items_sent, PhaseCnt + 1, rsp_seen);
    $display("%0d walks hit the limit, %0d free scans found nothing, %0d mismatches.",
             limit_hits, nofree_hits, mismatches);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- fat_cluster_table_engine_unit.f -----
rtl/fcte_pkg.sv
rtl/fcte_link_ram.sv
rtl/fcte_engine.sv
rtl/fat_cluster_table_engine_unit.sv
bench/tb_fat_cluster_table_engine_unit.sv
